// File: design/thdt_pkg.sv
// Package for the trace hash dedup table: sizes, hash constants and codes.
// Used by the datapath, the controller and the top level.
package thdt_pkg;
  localparam int TableSlots = 1024;
  localparam int SlotBits = $clog2(TableSlots);
  localparam int MaxFrames = 1024;
  localparam logic [63:0] MIX_MUL = 64'hc6a4a7935bd1e995;
  localparam int MixShift = 47;
  localparam logic [63:0] OVERFLOW_ID = 64'h7fffffffffffffff;
  localparam logic [63:0] DROPPED_ID = 64'd1;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_NEW      = 2'd1,
    OUT_OVERFLOW = 2'd2,
    OUT_DROPPED  = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED,
    OP_MUL_K1,
    OP_MUL_K2,
    OP_MUL_H,
    OP_FIN1,
    OP_PROBE_START,
    OP_PROBE_NEXT,
    OP_INSERT,
    OP_CLEAR_START,
    OP_CLEAR_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_start;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic key_match;
    logic key_empty;
    logic probe_last;
    logic clear_last;
    logic hash_zero;
  } dp_status_t;
endpackage

// File: design/thdt_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
module thdt_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/thdt_mul64.sv
// Sequential 64x64 low-half multiplier built from 32x32 partial products.
// Depends on nothing; used by the datapath.
module thdt_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        done
);
  logic [1:0]  phase;
  logic [31:0] a_lo, a_hi, b_lo, b_hi;
  logic [63:0] ll;
  logic [31:0] lh, hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        2'd0: begin
          if (start) begin
            a_lo  <= a[31:0];
            a_hi  <= a[63:32];
            b_lo  <= b[31:0];
            b_hi  <= b[63:32];
            phase <= 2'd1;
          end
        end
        2'd1: begin
          ll    <= 64'(a_lo) * 64'(b_lo);
          phase <= 2'd2;
        end
        2'd2: begin
          lh    <= 32'(a_lo * b_hi);
          hl    <= 32'(a_hi * b_lo);
          phase <= 2'd3;
        end
        default: begin
          p     <= ll + {lh + hl, 32'd0};
          done  <= 1'b1;
          phase <= 2'd0;
        end
      endcase
    end
  end
endmodule

// File: design/thdt_datapath.sv
// Datapath of the trace hash dedup table: hash registers, multiplier,
// probe address logic and the key and id memories. Uses thdt_pkg.
module thdt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  thdt_pkg::dp_cmd_t    cmd,
  output thdt_pkg::dp_status_t status,
  input  logic [63:0]          frame_word,
  input  logic [10:0]          frame_count,
  input  logic                 is_truncated,
  input  logic [31:0]          instance_tag,
  output logic [63:0]          id_read,
  output logic [63:0]          id_new
);
  import thdt_pkg::*;

  logic [63:0] h, mul_a, mul_p;
  logic        mul_done;
  logic [SlotBits-1:0] slot, step, addr;
  logic [SlotBits-1:0] clear_ptr;
  logic        key_we, id_we;
  logic [63:0] key_wdata, key_rdata;

  // The multiplier operand is forwarded straight from the last product, so
  // the next multiply of a chain starts in the cycle the previous one ends.
  always_comb begin
    mul_a = h;
    case (cmd.op)
      OP_SEED, OP_NONE: mul_a = frame_word;
      OP_MUL_K1:        mul_a = mul_p ^ (mul_p >> MixShift);
      OP_MUL_K2:        mul_a = h ^ mul_p;
      OP_MUL_H:         mul_a = mul_p ^ (mul_p >> MixShift);
      default:          mul_a = h;
    endcase
  end

  thdt_mul64 u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(mul_a), .b(MIX_MUL),
    .p(mul_p), .done(mul_done)
  );

  always_comb begin
    addr      = slot;
    key_we    = 1'b0;
    id_we     = 1'b0;
    key_wdata = h;
    case (cmd.op)
      OP_PROBE_START: addr = h[SlotBits-1:0];
      OP_PROBE_NEXT:  addr = slot + step + SlotBits'(1);
      OP_INSERT: begin
        key_we = 1'b1;
        id_we  = 1'b1;
      end
      OP_CLEAR_START: begin
        addr      = '0;
        key_we    = 1'b1;
        key_wdata = '0;
      end
      OP_CLEAR_STEP: begin
        addr      = clear_ptr;
        key_we    = 1'b1;
        key_wdata = '0;
      end
      default: addr = slot;
    endcase
  end

  assign id_new = {instance_tag, {(32 - SlotBits){1'b0}}, slot};

  thdt_ram #(.Width(64), .Depth(TableSlots)) u_keys (
    .clk(clk), .we(key_we), .addr(addr), .wdata(key_wdata), .rdata(key_rdata)
  );
  thdt_ram #(.Width(64), .Depth(TableSlots)) u_ids (
    .clk(clk), .we(id_we), .addr(addr), .wdata(id_new), .rdata(id_read)
  );

  // The sweep pointer starts at zero after reset, so the sweep that follows
  // reset covers every slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR_START: clear_ptr <= SlotBits'(1);
        OP_CLEAR_STEP:  clear_ptr <= clear_ptr + SlotBits'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SEED: begin
        h <= 64'(({53'd0, frame_count} << 4) * MIX_MUL) << (is_truncated ? 0 : 1);
      end
      OP_MUL_K2: if (mul_done) h <= h ^ mul_p;
      OP_MUL_H:  if (mul_done) h <= mul_p;
      OP_FIN1:   if (mul_done) h <= mul_p ^ (mul_p >> MixShift);
      OP_PROBE_START: begin
        slot <= h[SlotBits-1:0];
        step <= '0;
      end
      OP_PROBE_NEXT: begin
        slot <= addr;
        step <= step + SlotBits'(1);
      end
      default: ;
    endcase
  end

  assign status.mul_done   = mul_done;
  assign status.key_match  = (key_rdata == h);
  assign status.key_empty  = (key_rdata == 64'd0);
  assign status.probe_last = (step == SlotBits'(TableSlots - 1));
  assign status.clear_last = (clear_ptr == SlotBits'(TableSlots - 1));
  assign status.hash_zero  = (h == 64'd0);
endmodule

// File: design/thdt_ctrl.sv
// Controller state machine for the trace hash dedup table.
// Uses thdt_pkg; drives the datapath by command and reads its status.
module thdt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 action,
  input  logic [10:0]          frame_count,
  input  logic                 last_word,
  output logic                 busy,
  output thdt_pkg::dp_cmd_t    cmd,
  input  thdt_pkg::dp_status_t status,
  input  logic [63:0]          id_read,
  input  logic [63:0]          id_new,
  output logic                 done,
  output logic [63:0]          result_id,
  output logic [1:0]           outcome
);
  import thdt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_K1, S_K2, S_H, S_FIN1, S_FIN2, S_DECIDE, S_PROBE, S_WAIT,
    S_CLEAR
  } state_t;

  state_t state;
  logic first, none, bad, last_q;
  logic [31:0] overflow_count;
  logic [10:0] entry_count;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    cmd.mul_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (start && action) begin
          cmd.op = OP_CLEAR_START;
        end else if (start) begin
          if (first) cmd.op = OP_SEED;
          cmd.mul_start = !(first ? (frame_count == 11'd0) : none);
        end
      end
      S_K1: begin
        cmd.op = OP_MUL_K1;
        cmd.mul_start = status.mul_done;
      end
      S_K2: begin
        cmd.op = OP_MUL_K2;
        cmd.mul_start = status.mul_done;
      end
      S_H: begin
        cmd.op = OP_MUL_H;
        cmd.mul_start = status.mul_done && last_q;
      end
      S_FIN1:   cmd.op = OP_FIN1;
      S_DECIDE: cmd.op = OP_PROBE_START;
      S_PROBE: begin
        if (status.key_match) cmd.op = OP_NONE;
        else if (status.key_empty) cmd.op = OP_INSERT;
        else if (!status.probe_last) cmd.op = OP_PROBE_NEXT;
      end
      S_CLEAR:  cmd.op = OP_CLEAR_STEP;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      first <= 1'b1;
      none <= 1'b0;
      bad <= 1'b0;
      last_q <= 1'b0;
      done <= 1'b0;
      overflow_count <= '0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && action) begin
            first <= 1'b1;
            none <= 1'b0;
            bad <= 1'b0;
            overflow_count <= '0;
            entry_count <= '0;
            state <= S_CLEAR;
          end else if (start) begin
            first <= 1'b0;
            last_q <= last_word;
            if (first) begin
              none <= (frame_count == 11'd0);
              bad <= (frame_count > 11'(MaxFrames));
            end
            if (cmd.mul_start) state <= S_K1;
            else if (last_word) state <= S_FIN2;
          end
        end
        S_K1: if (status.mul_done) state <= S_K2;
        S_K2: if (status.mul_done) state <= S_H;
        S_H: begin
          if (status.mul_done) state <= last_q ? S_FIN1 : S_IDLE;
        end
        S_FIN1: if (status.mul_done) state <= S_FIN2;
        S_FIN2: begin
          first <= 1'b1;
          none <= 1'b0;
          bad <= 1'b0;
          if (bad || status.hash_zero) begin
            done <= 1'b1;
            result_id <= DROPPED_ID;
            outcome <= OUT_DROPPED;
            state <= S_IDLE;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: state <= S_WAIT;
        S_WAIT: state <= S_PROBE;
        S_PROBE: begin
          if (status.key_match) begin
            done <= 1'b1;
            result_id <= id_read;
            outcome <= OUT_FOUND;
            state <= S_IDLE;
          end else if (status.key_empty) begin
            done <= 1'b1;
            result_id <= id_new;
            outcome <= OUT_NEW;
            if (entry_count != 11'd2047) entry_count <= entry_count + 11'd1;
            state <= S_IDLE;
          end else if (status.probe_last) begin
            done <= 1'b1;
            result_id <= OVERFLOW_ID;
            outcome <= OUT_OVERFLOW;
            overflow_count <= overflow_count + 32'd1;
            state <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_CLEAR: if (status.clear_last) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/trace_hash_dedup_table.sv
// Top level of the trace hash dedup table: controller, datapath, tag register.
// Depends on thdt_pkg, thdt_ctrl, thdt_datapath, thdt_mul64 and thdt_ram.
//
//   channel   handshake             payload
//   input     start, busy           action, frame_word, frame_count,
//                                   is_truncated, last_word
//   result    done (one cycle)      result_id, outcome
//   config    instance_tag_we       instance_tag_wdata
//
// A word that is mixed keeps busy high for three 64-bit multiplies, run in turn
// on the shared multiplier from 32x32 partial products, so the next word is
// taken only once busy falls. A last word adds a fourth multiply; done then rises
// after it for a dropped trace, or else once the first probed slot or a further
// probed slot decides, or with an overflow once the last probe step has failed.
// A last word of a zero-frame trace gives done with no multiply at all.
// A clear keeps busy high while the key RAM is swept one slot a cycle; after
// reset the same sweep keeps busy high. The receiver cannot stall, so done lasts
// one cycle.
module trace_hash_dedup_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] frame_word,
  input  logic [10:0] frame_count,
  input  logic        is_truncated,
  input  logic        last_word,
  input  logic        instance_tag_we,
  input  logic [31:0] instance_tag_wdata,
  output logic        done,
  output logic [63:0] result_id,
  output logic [1:0]  outcome
);
  import thdt_pkg::*;

  logic [31:0] instance_tag;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [63:0] id_read, id_new;

  // The tag register takes a write at any edge; the host must write it only while
  // the block is idle, so an insert always sees a settled tag; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      instance_tag <= '0;
    end else begin
      if (instance_tag_we) instance_tag <= instance_tag_wdata;
    end
  end

  thdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .frame_count(frame_count), .last_word(last_word), .busy(busy),
    .cmd(cmd), .status(status), .id_read(id_read), .id_new(id_new),
    .done(done), .result_id(result_id), .outcome(outcome)
  );

  thdt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .frame_word(frame_word), .frame_count(frame_count),
    .is_truncated(is_truncated), .instance_tag(instance_tag),
    .id_read(id_read), .id_new(id_new)
  );
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for trace_hash_dedup_table: drives hashed call traces and clears,
// predicts every result id and outcome in its own model, and checks each result.
// Depends on thdt_pkg and the trace_hash_dedup_table RTL.
module tb_top;
  import thdt_pkg::*;

  // One expected result: the id and the outcome that a last word must produce.
  typedef struct {
    logic [63:0] id;
    outcome_t    code;
  } lookup_t;

  // A trace is regenerated from its seed, so it can be sent again later to hit
  // an existing table entry.
  typedef struct {
    logic [63:0] seed;
    logic [10:0] frames;
    logic        trunc;
    int          nwords;
  } trace_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = 1'b0;
  logic [63:0] frame_word = '0;
  logic [10:0] frame_count = '0;
  logic        is_truncated = 1'b0;
  logic        last_word = 1'b0;
  logic        instance_tag_we = 1'b0;
  logic [31:0] instance_tag_wdata = '0;
  logic        done;
  logic [63:0] result_id;
  logic [1:0]  outcome;

  // Shadow of the table, the running hash and the tag register.
  logic [63:0] key_mem [TableSlots];
  logic [63:0] id_mem [TableSlots];
  logic [63:0] hash_acc;
  logic        at_first_word;
  logic        no_frames;
  logic        too_many_frames;
  logic [31:0] tag_shadow;

  lookup_t     pending_lookups[$];
  trace_t      sent_traces[$];
  int          error_count = 0;
  int          word_count = 0;

  trace_hash_dedup_table u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .action             (action),
    .frame_word         (frame_word),
    .frame_count        (frame_count),
    .is_truncated       (is_truncated),
    .last_word          (last_word),
    .instance_tag_we    (instance_tag_we),
    .instance_tag_wdata (instance_tag_wdata),
    .done               (done),
    .result_id          (result_id),
    .outcome            (outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run must end long before this even with overflow probes and clears.
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] murmur_mix(logic [63:0] h, logic [63:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MixShift);
    k = k * MIX_MUL;
    h = h ^ k;
    return h * MIX_MUL;
  endfunction

  function automatic logic [63:0] murmur_finish(logic [63:0] h);
    h = h ^ (h >> MixShift);
    h = h * MIX_MUL;
    return h ^ (h >> MixShift);
  endfunction

  // Word i of a trace is a scrambled function of its seed, so all bits toggle.
  function automatic logic [63:0] trace_word(logic [63:0] seed, int i);
    return murmur_mix(seed, seed + 64'(i));
  endfunction

  task automatic clear_shadow();
    for (int s = 0; s < TableSlots; s++) key_mem[s] = '0;
    restart_stream();
  endtask

  task automatic restart_stream();
    hash_acc = '0;
    at_first_word = 1'b1;
    no_frames = 1'b0;
    too_many_frames = 1'b0;
  endtask

  // Applies one accepted word to the shadow and queues the lookup it causes.
  task automatic predict_lookup(logic act, logic [63:0] w, logic [10:0] frames,
                                logic trunc, logic last);
    logic [63:0] h;
    logic        drop;
    int          slot;
    int          step;
    lookup_t     res;
    if (act) begin
      clear_shadow();
      return;
    end
    if (at_first_word) begin
      // The seed is the byte length times the multiplier, doubled when whole.
      hash_acc = (64'(frames) * 64'd16) * MIX_MUL * (trunc ? 64'd1 : 64'd2);
      no_frames = (frames == 0);
      too_many_frames = (frames > MaxFrames);
      at_first_word = 1'b0;
    end
    if (!no_frames) hash_acc = murmur_mix(hash_acc, w);
    if (!last) return;
    h = murmur_finish(hash_acc);
    drop = too_many_frames || (h == 0);
    restart_stream();
    if (drop) begin
      res.id = DROPPED_ID;
      res.code = OUT_DROPPED;
      pending_lookups.push_back(res);
      return;
    end
    // Triangular probing from the low hash bits until a match, a hole, or a
    // full sweep of the table.
    slot = int'(h[SlotBits-1:0]);
    step = 0;
    forever begin
      if (key_mem[slot] == h) begin
        res.id = id_mem[slot];
        res.code = OUT_FOUND;
        break;
      end
      if (key_mem[slot] == 0) begin
        key_mem[slot] = h;
        id_mem[slot] = {tag_shadow, 32'(slot)};
        res.id = id_mem[slot];
        res.code = OUT_NEW;
        break;
      end
      step++;
      if (step >= TableSlots) begin
        res.id = OVERFLOW_ID;
        res.code = OUT_OVERFLOW;
        break;
      end
      slot = (slot + step) % TableSlots;
    end
    pending_lookups.push_back(res);
  endtask

  // Sends one word. It is called at a falling edge and returns at one. A zero
  // gap leaves start high, so the next word follows back to back.
  task automatic send_word(logic act, logic [63:0] w, logic [10:0] frames,
                           logic trunc, logic last);
    int gap;
    action <= act;
    frame_word <= w;
    frame_count <= frames;
    is_truncated <= trunc;
    last_word <= last;
    start <= 1'b1;
    // The word is taken at the first rising edge at which busy is low.
    do @(posedge clk); while (busy);
    @(negedge clk);
    predict_lookup(act, w, frames, trunc, last);
    word_count++;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_trace(trace_t t);
    for (int i = 0; i < t.nwords; i++) begin
      send_word(1'b0, trace_word(t.seed, i), t.frames, t.trunc, i == t.nwords - 1);
    end
  endtask

  task automatic send_clear();
    send_word(1'b1, {$urandom, $urandom}, 11'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Waits until every lookup has come back and the block has gone idle. A
  // trailing word that causes no result may still be mixing, hence the pause.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_lookups.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_tag(logic [31:0] tag);
    wait_idle();
    instance_tag_we <= 1'b1;
    instance_tag_wdata <= tag;
    @(negedge clk);
    instance_tag_we <= 1'b0;
    tag_shadow = tag;
  endtask

  function automatic trace_t fresh_trace(int max_frames);
    trace_t t;
    t.seed = {$urandom, $urandom};
    t.frames = 11'($urandom_range(1, max_frames));
    t.trunc = 1'($urandom);
    t.nwords = 2 * t.frames;
    return t;
  endfunction

  // Each result word is compared against the oldest lookup still waiting.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result id=%h outcome=%0d", $time, result_id, outcome);
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (result_id !== want.id) begin
          $display("%0t: result_id expected %h actual %h", $time, want.id, result_id);
          error_count++;
        end
        if (outcome !== want.code) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.code, outcome);
          error_count++;
        end
      end
    end
  end

  // Extremes of every field, dropped traces, a repeat hit and a clear.
  task automatic test_directed();
    trace_t t;
    send_word(1'b0, 64'd0, 11'd1, 1'b1, 1'b0);
    send_word(1'b0, '1, 11'd1, 1'b1, 1'b1);
    send_word(1'b0, '1, 11'd1, 1'b1, 1'b0);
    send_word(1'b0, 64'd0, 11'd1, 1'b1, 1'b1);
    // Zero frames: words are not mixed, the hash is zero and the trace drops.
    send_word(1'b0, '1, 11'd0, 1'b0, 1'b0);
    send_word(1'b0, '1, 11'd0, 1'b0, 1'b1);
    // Too many frames drops, as does the widest frame count.
    send_word(1'b0, 64'h0123456789abcdef, 11'd1025, 1'b0, 1'b1);
    send_word(1'b0, 64'hfedcba9876543210, 11'd2047, 1'b1, 1'b1);
    // The largest legal count with only a few words: no count check is made.
    send_word(1'b0, 64'h8000000000000001, 11'd1024, 1'b0, 1'b0);
    send_word(1'b0, 64'h7ffffffffffffffe, 11'd1024, 1'b0, 1'b1);
    // The same trace twice must find the id given the first time.
    t = fresh_trace(3);
    sent_traces.push_back(t);
    send_trace(t);
    send_trace(t);
    // After a clear the same trace is new again.
    send_clear();
    send_trace(t);
    send_word(1'b0, 64'h5555555555555555, 11'd1, 1'b0, 1'b1);
    send_word(1'b0, 64'haaaaaaaaaaaaaaaa, 11'd1, 1'b0, 1'b1);
  endtask

  // Fills all slots, then drives the full-table overflow and some hits.
  task automatic test_table_fill();
    trace_t fill_traces[$];
    trace_t t;
    send_clear();
    for (int i = 0; i < TableSlots + 6; i++) begin
      t.seed = {$urandom, $urandom};
      t.frames = 11'd1;
      t.trunc = 1'($urandom);
      t.nwords = 1;
      fill_traces.push_back(t);
      send_trace(t);
    end
    for (int i = 0; i < 8; i++) begin
      send_trace(fill_traces[$urandom_range(0, fill_traces.size() - 1)]);
    end
    send_clear();
  endtask

  // Mostly well-formed traces with random content, many of them repeats, and
  // some noise: odd word counts, zero or oversized frame counts, clears.
  task automatic test_random(int words);
    trace_t t;
    int     pick;
    int     target;
    target = word_count + words;
    while (word_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && sent_traces.size() > 0) begin
        send_trace(sent_traces[$urandom_range(0, sent_traces.size() - 1)]);
      end else if (pick < 85) begin
        t = fresh_trace(($urandom_range(0, 30) == 0) ? 12 : 4);
        sent_traces.push_back(t);
        send_trace(t);
      end else if (pick < 97) begin
        t = fresh_trace(4);
        case ($urandom_range(0, 2))
          0: t.frames = 11'd0;
          1: t.frames = 11'($urandom_range(MaxFrames + 1, 2047));
          default: ;
        endcase
        t.nwords = $urandom_range(1, 7);
        sent_traces.push_back(t);
        send_trace(t);
      end else begin
        send_clear();
      end
    end
  endtask

  initial begin
    tag_shadow = '0;
    clear_shadow();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    set_tag(32'hffffffff);
    test_table_fill();
    set_tag(32'h00000000);
    test_random(120);
    set_tag($urandom);
    test_random(120);
    set_tag(32'hffffffff);
    test_random(120);

    wait_idle();
    repeat (50) @(negedge clk);
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
